### rtl/core/path_string_validator_macros.svh
// Assertion macros used by the path validator top level.
`ifndef PATH_STRING_VALIDATOR_MACROS_SVH
`define PATH_STRING_VALIDATOR_MACROS_SVH

// Clocked property, switched off while reset is held.
`define PSV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define PSV_ASSERT_NEVER(label, cond, msg) \
    `PSV_ASSERT(label, !(cond), msg)

`endif

### rtl/core/psv_pkg.sv
// Types, constants and helper functions of the path validator.
`default_nettype none

package psv_pkg;

    // Length counters and their comparison width.
    localparam int COUNT_WIDTH = 17;
    localparam int LIMIT_WIDTH = 16;
    localparam int CMP_WIDTH   = COUNT_WIDTH + LIMIT_WIDTH;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 40;
    localparam int PREFIX_BYTES = 5;

    // Byte values with a meaning of their own.
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DEL       = 8'h7f;
    localparam logic [7:0] CHAR_SLASH     = 8'h2f;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_DOT       = 8'h2e;

    // Reset values of the registers.
    localparam logic [LIMIT_WIDTH-1:0] RESET_MAX_PATH = 16'd1024;
    localparam logic [LIMIT_WIDTH-1:0] RESET_MAX_SEG  = 16'd255;
    localparam logic [CFG_DATA_W-1:0]  RESET_PREFIX   = 40'h2E7078612D;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_PATH = 2'd0,
        CFG_MAX_SEG  = 2'd1,
        CFG_PREFIX   = 2'd2
    } t_cfg_index;

    // Allowed range of the next UTF-8 continuation byte.
    typedef enum logic [2:0] {
        RNG_80_BF = 3'd0,
        RNG_A0_BF = 3'd1,
        RNG_80_9F = 3'd2,
        RNG_90_BF = 3'd3,
        RNG_80_8F = 3'd4
    } t_range;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] max_path_bytes;
        logic [LIMIT_WIDTH-1:0] max_segment_bytes;
        logic [CFG_DATA_W-1:0]  reserved_prefix;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] path_count;
        logic [COUNT_WIDTH-1:0] segment_count;
        logic                   prefix_matching;
        logic                   dots_only;
        logic [1:0]             utf8_remaining;
        t_range                 utf8_next_range;
        logic                   path_failed;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        path_count:      '0,
        segment_count:   '0,
        prefix_matching: 1'b1,
        dots_only:       1'b1,
        utf8_remaining:  2'd0,
        utf8_next_range: RNG_80_BF,
        path_failed:     1'b0
    };

    // Byte of the reserved prefix at a segment position; position 0 is the top byte.
    function automatic logic [7:0] prefix_byte(input logic [CFG_DATA_W-1:0] prefix,
                                               input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = prefix[39:32];
            3'd1:    b = prefix[31:24];
            3'd2:    b = prefix[23:16];
            3'd3:    b = prefix[15:8];
            3'd4:    b = prefix[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/core/psv_step.sv
// Next-state logic of the path validator for one byte beat.
`default_nettype none

module psv_step (
    input  var psv_pkg::t_cfg   i_cfg,
    input  var psv_pkg::t_state i_state,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    output psv_pkg::t_state     o_state,
    output logic                o_path_valid
);
    import psv_pkg::*;

    t_state     s;
    logic       fail;
    logic [7:0] lo;
    logic [7:0] hi;

    always_comb begin
        s    = i_state;
        fail = i_state.path_failed;
        lo   = 8'h80;
        hi   = 8'hbf;

        // Whole-path length, saturating at all ones.
        if (&i_state.path_count) begin
            fail = 1'b1;
        end else begin
            s.path_count = i_state.path_count + 1'b1;
        end
        if (CMP_WIDTH'(s.path_count) > CMP_WIDTH'(i_cfg.max_path_bytes)) begin
            fail = 1'b1;
        end

        if (i_byte == CHAR_SLASH) begin
            // A slash closes the segment built so far.
            if (i_state.segment_count == '0) begin
                fail = 1'b1;
            end
            if (i_state.dots_only && i_state.segment_count <= COUNT_WIDTH'(2)) begin
                fail = 1'b1;
            end
            if (i_state.utf8_remaining != 2'd0) begin
                fail = 1'b1;
            end
            s.segment_count   = '0;
            s.prefix_matching = 1'b1;
            s.dots_only       = 1'b1;
            s.utf8_remaining  = 2'd0;
            s.utf8_next_range = RNG_80_BF;
            // A trailing slash leaves an empty last segment.
            if (i_last) begin
                fail = 1'b1;
            end
        end else begin
            // Forbidden control bytes and the backslash.
            if (i_byte < CHAR_SPACE || i_byte == CHAR_DEL || i_byte == CHAR_BACKSLASH) begin
                fail = 1'b1;
            end

            // Reserved prefix at the start of the segment.
            if (i_state.segment_count < COUNT_WIDTH'(PREFIX_BYTES) &&
                i_state.prefix_matching) begin
                if (i_byte != prefix_byte(i_cfg.reserved_prefix,
                                          i_state.segment_count[2:0])) begin
                    s.prefix_matching = 1'b0;
                end else if (i_state.segment_count[2:0] == 3'(PREFIX_BYTES - 1)) begin
                    fail = 1'b1;
                end
            end

            if (i_byte != CHAR_DOT) begin
                s.dots_only = 1'b0;
            end

            // Segment length, saturating at all ones.
            if (&i_state.segment_count) begin
                fail = 1'b1;
            end else begin
                s.segment_count = i_state.segment_count + 1'b1;
            end
            if (CMP_WIDTH'(s.segment_count) > CMP_WIDTH'(i_cfg.max_segment_bytes)) begin
                fail = 1'b1;
            end

            // Strict UTF-8 decoding.
            if (i_state.utf8_remaining != 2'd0) begin
                case (i_state.utf8_next_range)
                    RNG_A0_BF: lo = 8'ha0;
                    RNG_80_9F: hi = 8'h9f;
                    RNG_90_BF: lo = 8'h90;
                    RNG_80_8F: hi = 8'h8f;
                    default:   lo = 8'h80;
                endcase
                if (i_byte >= lo && i_byte <= hi) begin
                    s.utf8_remaining  = i_state.utf8_remaining - 2'd1;
                    s.utf8_next_range = RNG_80_BF;
                end else begin
                    fail              = 1'b1;
                    s.utf8_remaining  = 2'd0;
                    s.utf8_next_range = RNG_80_BF;
                end
            end else if (i_byte >= 8'h80) begin
                if (i_byte >= 8'hc2 && i_byte <= 8'hdf) begin
                    s.utf8_remaining  = 2'd1;
                    s.utf8_next_range = RNG_80_BF;
                end else if (i_byte == 8'he0) begin
                    s.utf8_remaining  = 2'd2;
                    s.utf8_next_range = RNG_A0_BF;
                end else if (i_byte == 8'hed) begin
                    s.utf8_remaining  = 2'd2;
                    s.utf8_next_range = RNG_80_9F;
                end else if (i_byte >= 8'he1 && i_byte <= 8'hef) begin
                    s.utf8_remaining  = 2'd2;
                    s.utf8_next_range = RNG_80_BF;
                end else if (i_byte == 8'hf0) begin
                    s.utf8_remaining  = 2'd3;
                    s.utf8_next_range = RNG_90_BF;
                end else if (i_byte >= 8'hf1 && i_byte <= 8'hf3) begin
                    s.utf8_remaining  = 2'd3;
                    s.utf8_next_range = RNG_80_BF;
                end else if (i_byte == 8'hf4) begin
                    s.utf8_remaining  = 2'd3;
                    s.utf8_next_range = RNG_80_8F;
                end else begin
                    fail = 1'b1;
                end
            end

            // The final byte also closes the last segment.
            if (i_last) begin
                if (s.dots_only && s.segment_count <= COUNT_WIDTH'(2)) begin
                    fail = 1'b1;
                end
                if (s.utf8_remaining != 2'd0) begin
                    fail = 1'b1;
                end
            end
        end

        s.path_failed = fail;

        // The path result is taken at its final byte and the state starts afresh.
        o_path_valid = !fail;
        if (i_last) begin
            o_state = STATE_CLEAR;
        end else begin
            o_state = s;
        end
    end

endmodule

`default_nettype wire

### rtl/core/path_string_validator.sv
// A path's verdict is registered after its last byte beat, in the output register or, while it is held, the skid entry.
// Throughput: one byte beat per cycle while o_in_stall is low, set by the per-byte state update.
// A two-entry output register and skid stage keep input beats flowing while a verdict waits.
// Reset (synchronous, active low) clears the path state and output, and loads register defaults.
`default_nettype none

module path_string_validator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_path_byte,
    input  wire logic                          i_last_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_path_valid,
    input  wire logic                          i_cfg_we,
    input  wire logic [psv_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [psv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import psv_pkg::*;
    `include "path_string_validator_macros.svh"

    t_cfg   r_cfg;
    t_state r_state;
    t_state step_state;
    logic   step_valid;
    logic   in_accept;
    logic   res_valid;

    logic   r_out_valid;
    logic   n_out_valid;
    logic   r_out_data;
    logic   n_out_data;
    logic   r_skid_valid;
    logic   n_skid_valid;
    logic   r_skid_data;
    logic   n_skid_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_path_bytes    <= RESET_MAX_PATH;
            r_cfg.max_segment_bytes <= RESET_MAX_SEG;
            r_cfg.reserved_prefix   <= RESET_PREFIX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_PATH: r_cfg.max_path_bytes    <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_MAX_SEG:  r_cfg.max_segment_bytes <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_PREFIX:   r_cfg.reserved_prefix   <= i_cfg_data;
                default:      r_cfg                   <= r_cfg;
            endcase
        end
    end

    // Per-byte rule checks.
    psv_step u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_byte       (i_path_byte),
        .i_last       (i_last_byte),
        .o_state      (step_state),
        .o_path_valid (step_valid)
    );

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign res_valid  = in_accept && i_last_byte;

    // Path state advances on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (in_accept) begin
            r_state <= step_state;
        end
    end

    // Output register with a skid entry behind it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out_data  = step_valid;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid_data  = step_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out_valid  = r_out_valid;
    assign o_path_valid = r_out_data;

    // The skid entry is only ever filled behind a held output.
    `PSV_ASSERT_NEVER(a_skid_behind_out, r_skid_valid && !r_out_valid, "skid full with output empty")
    // A final byte leaves the path state cleared.
    `PSV_ASSERT(a_clear_after_last, (in_accept && i_last_byte) |=> (r_state.path_count == '0 && !r_state.path_failed && r_state.segment_count == '0), "path state not cleared after final byte")
    // The segment never holds more bytes than the path.
    `PSV_ASSERT_NEVER(a_seg_le_path, r_state.segment_count > r_state.path_count, "segment count above path count")
    // No open UTF-8 sequence means the ordinary continuation range.
    `PSV_ASSERT_NEVER(a_range_idle, r_state.utf8_remaining == 2'd0 && r_state.utf8_next_range != RNG_80_BF, "continuation range set with no sequence open")

endmodule

`default_nettype wire

### dv/path_string_validator_test.sv
// Self-checking testbench of the path string validator: directed, limit, length, back-pressure and random paths.
`default_nettype none

module path_string_validator_test;

    import psv_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned RANDOM_BYTES = 900;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [7:0]             i_path_byte;
    logic                   i_last_byte;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_path_valid;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    path_string_validator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_path_byte (i_path_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_path_valid(o_path_valid),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Register copies and path state of the predictor.
    logic [LIMIT_WIDTH-1:0] max_path;
    logic [LIMIT_WIDTH-1:0] max_seg;
    logic [CFG_DATA_W-1:0]  prefix_cfg;
    logic [COUNT_WIDTH-1:0] path_len;
    logic [COUNT_WIDTH-1:0] seg_len;
    logic                   prefix_hit;
    logic                   dots_only;
    logic [1:0]             utf8_owed;
    t_range                 utf8_range;
    logic                   path_bad;

    // Verdicts still to come from the block, oldest first.
    logic expected_verdicts[$];
    // Bytes of the path being assembled for sending.
    logic [7:0] path_buf[$];

    bit          sender_calm;
    bit          receiver_calm;
    int unsigned hold_cycles;
    int unsigned fail_count;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Byte of the reserved prefix at a segment position; position 0 is the first byte.
    function automatic logic [7:0] reserved_byte(input int unsigned pos);
        return prefix_cfg[8*(4-pos) +: 8];
    endfunction

    function automatic void clear_segment();
        seg_len    = '0;
        prefix_hit = 1'b1;
        dots_only  = 1'b1;
        utf8_owed  = 2'd0;
        utf8_range = RNG_80_BF;
    endfunction

    function automatic void clear_path();
        clear_segment();
        path_len = '0;
        path_bad = 1'b0;
    endfunction

    // A segment fails if empty, a dot or two dots, or left inside a UTF-8 sequence.
    function automatic void close_segment();
        if (seg_len == 0) path_bad = 1'b1;
        if (dots_only && seg_len <= 2) path_bad = 1'b1;
        if (utf8_owed != 0) path_bad = 1'b1;
        clear_segment();
    endfunction

    // Advances the predicted path state by one accepted byte beat.
    task automatic track_path_byte(input logic [7:0] b, input logic is_last);
        logic [7:0]  lo;
        logic [7:0]  hi;
        int unsigned pos;
        if (&path_len) path_bad = 1'b1;
        else path_len++;
        if (path_len > max_path) path_bad = 1'b1;

        if (b == CHAR_SLASH) begin
            close_segment();
            if (is_last) path_bad = 1'b1;
        end else begin
            if (b < CHAR_SPACE || b == CHAR_DEL || b == CHAR_BACKSLASH) path_bad = 1'b1;

            // Reserved prefix at the head of the segment.
            if (seg_len < 5 && prefix_hit) begin
                pos = seg_len;
                if (b != reserved_byte(pos)) prefix_hit = 1'b0;
                else if (pos == 4) path_bad = 1'b1;
            end

            if (b != CHAR_DOT) dots_only = 1'b0;
            if (&seg_len) path_bad = 1'b1;
            else seg_len++;
            if (seg_len > max_seg) path_bad = 1'b1;

            // Strict UTF-8: continuation byte in its allowed range, or a legal lead byte.
            if (utf8_owed != 0) begin
                lo = 8'h80;
                hi = 8'hbf;
                case (utf8_range)
                    RNG_A0_BF: lo = 8'ha0;
                    RNG_80_9F: hi = 8'h9f;
                    RNG_90_BF: lo = 8'h90;
                    RNG_80_8F: hi = 8'h8f;
                    default: ;
                endcase
                if (b >= lo && b <= hi) begin
                    utf8_owed--;
                end else begin
                    path_bad  = 1'b1;
                    utf8_owed = 2'd0;
                end
                utf8_range = RNG_80_BF;
            end else if (b >= 8'h80) begin
                if (b >= 8'hc2 && b <= 8'hdf) begin
                    utf8_owed = 2'd1; utf8_range = RNG_80_BF;
                end else if (b == 8'he0) begin
                    utf8_owed = 2'd2; utf8_range = RNG_A0_BF;
                end else if (b == 8'hed) begin
                    utf8_owed = 2'd2; utf8_range = RNG_80_9F;
                end else if (b >= 8'he1 && b <= 8'hef) begin
                    utf8_owed = 2'd2; utf8_range = RNG_80_BF;
                end else if (b == 8'hf0) begin
                    utf8_owed = 2'd3; utf8_range = RNG_90_BF;
                end else if (b >= 8'hf1 && b <= 8'hf3) begin
                    utf8_owed = 2'd3; utf8_range = RNG_80_BF;
                end else if (b == 8'hf4) begin
                    utf8_owed = 2'd3; utf8_range = RNG_80_8F;
                end else begin
                    path_bad = 1'b1;
                end
            end

            if (is_last) close_segment();
        end

        if (is_last) begin
            expected_verdicts.push_back(!path_bad);
            clear_path();
        end
    endtask

    // Offers one byte beat after a random gap and waits until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_path_byte <= b;
        i_last_byte <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        track_path_byte(b, is_last);
    endtask

    task automatic send_path();
        for (int i = 0; i < path_buf.size(); i++)
            send_byte(path_buf[i], i == path_buf.size() - 1);
        path_buf.delete();
    endtask

    function automatic void load_text(input string s);
        for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
    endfunction

    // Stops offering beats and lets every outstanding verdict arrive.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MAX_PATH: max_path   = data[LIMIT_WIDTH-1:0];
            CFG_MAX_SEG:  max_seg    = data[LIMIT_WIDTH-1:0];
            CFG_PREFIX:   prefix_cfg = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One character: mostly printable ASCII or well-formed UTF-8, sometimes broken or raw.
    task automatic add_char();
        logic [7:0]  lead;
        logic [7:0]  c;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            c = 8'($urandom_range(32, 127));
            if (c == CHAR_SLASH) c = 8'h61;
            path_buf.push_back(c);
        end else if (r < 56) begin
            path_buf.push_back(CHAR_DOT);
        end else if (r < 66) begin
            path_buf.push_back(8'($urandom_range(8'hc2, 8'hdf)));
            path_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end else if (r < 76) begin
            lead = 8'($urandom_range(8'he0, 8'hef));
            path_buf.push_back(lead);
            if (lead == 8'he0) c = 8'($urandom_range(8'ha0, 8'hbf));
            else if (lead == 8'hed) c = 8'($urandom_range(8'h80, 8'h9f));
            else c = 8'($urandom_range(8'h80, 8'hbf));
            path_buf.push_back(c);
            path_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end else if (r < 84) begin
            lead = 8'($urandom_range(8'hf0, 8'hf4));
            path_buf.push_back(lead);
            if (lead == 8'hf0) c = 8'($urandom_range(8'h90, 8'hbf));
            else if (lead == 8'hf4) c = 8'($urandom_range(8'h80, 8'h8f));
            else c = 8'($urandom_range(8'h80, 8'hbf));
            path_buf.push_back(c);
            path_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
            path_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end else if (r < 92) begin
            // Lead byte followed by anything, or by nothing at all.
            path_buf.push_back(8'($urandom_range(8'hc0, 8'hff)));
            if ($urandom_range(0, 1) == 1) path_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            path_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_segment(input int unsigned max_chars);
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            path_buf.push_back(CHAR_DOT);
        end else if (r == 1) begin
            repeat (2) path_buf.push_back(CHAR_DOT);
        end else if (r == 2) begin
            repeat (3) path_buf.push_back(CHAR_DOT);
        end else if (r == 3) begin
            for (int i = 0; i < PREFIX_BYTES; i++) path_buf.push_back(reserved_byte(i));
            if ($urandom_range(0, 1) == 1) add_char();
        end else if (r == 4) begin
            n = $urandom_range(1, PREFIX_BYTES - 1);
            for (int i = 0; i < n; i++) path_buf.push_back(reserved_byte(i));
            add_char();
        end else begin
            n = $urandom_range(1, max_chars);
            repeat (n) add_char();
        end
    endtask

    // A path of a few segments; sometimes stray slashes, sometimes raw noise.
    task automatic build_path(input int unsigned max_chars);
        int unsigned segs;
        int unsigned n;
        if ($urandom_range(0, 29) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) path_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 19) == 0) path_buf.push_back(CHAR_SLASH);
            segs = $urandom_range(1, 4);
            for (int i = 0; i < segs; i++) begin
                if (i != 0) begin
                    path_buf.push_back(CHAR_SLASH);
                    if ($urandom_range(0, 19) == 0) path_buf.push_back(CHAR_SLASH);
                end
                add_segment(max_chars);
            end
            if ($urandom_range(0, 19) == 0) path_buf.push_back(CHAR_SLASH);
        end
    endtask

    // Receiver: random hold-off per verdict beat, plus a long hold when asked.
    initial begin
        int unsigned wait_cycles;
        i_out_stall = 1'b0;
        forever begin
            if (hold_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            wait_cycles = receiver_calm ? 0 : $urandom_range(0, 6);
            if (wait_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare every verdict beat with the oldest prediction.
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: verdict with none expected, expected none, actual %0b",
                         $time, o_path_valid);
                fail_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (o_path_valid !== want) begin
                    $display("%0t: path verdict mismatch, expected %0b, actual %0b",
                             $time, want, o_path_valid);
                    fail_count++;
                end
            end
        end
    end

    // Short paths that hit each rule once under the reset settings.
    task automatic test_directed_paths();
        load_text("a");    send_path();
        load_text("/");    send_path();
        load_text("a//b"); send_path();
        load_text("..");   send_path();
        for (int i = 0; i < PREFIX_BYTES; i++) path_buf.push_back(reserved_byte(i));
        send_path();
        path_buf = '{8'h00, 8'hff};               send_path();
        path_buf = '{8'hed, 8'ha0, 8'h80};        send_path();
        path_buf = '{8'hf4, 8'h90, 8'h80, 8'h80}; send_path();
        path_buf = '{8'hc2};                      send_path();
        path_buf = '{8'hc2, CHAR_SLASH, 8'h61};   send_path();
        path_buf = '{8'he0, 8'h41};               send_path();
    endtask

    // Register extremes: zero, one and full-scale lengths, and several prefixes.
    task automatic test_length_limits();
        drain();
        cfg_write(CFG_MAX_PATH, CFG_DATA_W'(0));
        cfg_write(CFG_MAX_SEG, CFG_DATA_W'(0));
        load_text("a");    send_path();
        load_text("ab/c"); send_path();

        drain();
        cfg_write(CFG_MAX_PATH, CFG_DATA_W'(1));
        cfg_write(CFG_MAX_SEG, CFG_DATA_W'(1));
        load_text("a");   send_path();
        load_text("ab");  send_path();
        load_text("a/b"); send_path();

        drain();
        cfg_write(CFG_MAX_PATH, CFG_DATA_W'(5));
        cfg_write(CFG_MAX_SEG, CFG_DATA_W'(2));
        load_text("ab/cd");  send_path();
        load_text("ab/cde"); send_path();
        load_text("abc");    send_path();

        drain();
        cfg_write(CFG_MAX_PATH, CFG_DATA_W'(16'hffff));
        cfg_write(CFG_MAX_SEG, CFG_DATA_W'(16'hffff));
        cfg_write(CFG_PREFIX, '0);
        repeat (4) begin build_path(6); send_path(); end

        drain();
        cfg_write(CFG_PREFIX, '1);
        repeat (4) begin build_path(6); send_path(); end

        drain();
        cfg_write(CFG_PREFIX, 40'h6162636465);
        load_text("abcde");     send_path();
        load_text("abcdf");     send_path();
        load_text("xabcde");    send_path();
        load_text("abcd");      send_path();
        load_text("x/abcde/y"); send_path();

        drain();
        cfg_write(CFG_MAX_PATH, CFG_DATA_W'(RESET_MAX_PATH));
        cfg_write(CFG_MAX_SEG, CFG_DATA_W'(RESET_MAX_SEG));
        cfg_write(CFG_PREFIX, RESET_PREFIX);
    endtask

    // Long segments and paths right at and one past their limits.
    task automatic test_long_paths();
        drain();
        cfg_write(CFG_MAX_PATH, CFG_DATA_W'(48));
        cfg_write(CFG_MAX_SEG, CFG_DATA_W'(24));
        repeat (24) path_buf.push_back(8'h61);
        send_path();
        repeat (25) path_buf.push_back(8'h61);
        send_path();
        repeat (24) path_buf.push_back(8'h61);
        path_buf.push_back(CHAR_SLASH);
        repeat (23) path_buf.push_back(8'h62);
        send_path();
        repeat (24) path_buf.push_back(8'h61);
        path_buf.push_back(CHAR_SLASH);
        repeat (24) path_buf.push_back(8'h62);
        send_path();
        // The next path must start from cleared counters.
        load_text("ok/fine"); send_path();

        drain();
        cfg_write(CFG_MAX_PATH, CFG_DATA_W'(RESET_MAX_PATH));
        cfg_write(CFG_MAX_SEG, CFG_DATA_W'(RESET_MAX_SEG));
    endtask

    // Receiver holds off for a long stretch while short paths keep coming.
    task automatic test_output_backpressure();
        drain();
        sender_calm = 1'b1;
        hold_cycles = 400;
        repeat (40) begin build_path(2); send_path(); end
        sender_calm = 1'b0;
    endtask

    // Phases of random paths, each under fresh register settings.
    task automatic test_random_paths();
        int unsigned sent;
        int unsigned max_chars;
        logic [CFG_DATA_W-1:0] prefix;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            drain();
            case ($urandom_range(0, 3))
                0:       cfg_write(CFG_MAX_PATH, CFG_DATA_W'(16'hffff));
                1:       cfg_write(CFG_MAX_PATH, CFG_DATA_W'($urandom_range(4, 40)));
                2:       cfg_write(CFG_MAX_PATH, CFG_DATA_W'($urandom_range(0, 16'hffff)));
                default: cfg_write(CFG_MAX_PATH, CFG_DATA_W'(RESET_MAX_PATH));
            endcase
            case ($urandom_range(0, 3))
                0:       cfg_write(CFG_MAX_SEG, CFG_DATA_W'(16'hffff));
                1:       cfg_write(CFG_MAX_SEG, CFG_DATA_W'($urandom_range(2, 12)));
                2:       cfg_write(CFG_MAX_SEG, CFG_DATA_W'($urandom_range(0, 16'hffff)));
                default: cfg_write(CFG_MAX_SEG, CFG_DATA_W'(RESET_MAX_SEG));
            endcase
            // A printable prefix lets random segments run into it now and then.
            case ($urandom_range(0, 2))
                0: prefix = RESET_PREFIX;
                1: for (int i = 0; i < PREFIX_BYTES; i++)
                       prefix[8*i +: 8] = 8'($urandom_range(33, 126));
                default: prefix = {8'($urandom()), 32'($urandom())};
            endcase
            cfg_write(CFG_PREFIX, prefix);

            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            max_chars     = $urandom_range(1, 8);
            repeat (12) begin
                build_path(max_chars);
                sent += path_buf.size();
                send_path();
            end
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_path_byte = 8'h00;
        i_last_byte = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MAX_PATH;
        i_cfg_data  = '0;
        max_path    = RESET_MAX_PATH;
        max_seg     = RESET_MAX_SEG;
        prefix_cfg  = RESET_PREFIX;
        clear_path();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_paths();
        test_length_limits();
        test_long_paths();
        test_output_backpressure();
        test_random_paths();
        drain();

        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
